/* rtl/core/e2q_pkg.sv */
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package e2q_pkg;

  localparam int CORDIC_STEPS = 28;
  localparam int ANG_W = 16;
  localparam int Q_W = 16;
  localparam int CW = 34;
  localparam int ZW = 34;
  localparam int QW = 24;

  localparam logic signed [17:0] HALF_TURN = 18'sd23040;
  localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  // pi * 2^30 split as PI_DIV_HI * 23040 + PI_DIV_LO
  localparam logic [17:0] PI_DIV_HI = 18'(PI_Q30 / 32'd23040);
  localparam logic [14:0] PI_DIV_LO = 15'(PI_Q30 % 32'd23040);

  // 23040 = 512 * 45; divide by 45 as multiply by ceil(2^25 / 45), exact below 2^19
  localparam int RECIP_SHIFT = 25;
  localparam logic [19:0] RECIP_45 = 20'd745655;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } e2q_rot_t;

  typedef struct packed {
    e2q_rot_t roll;
    e2q_rot_t pitch;
    e2q_rot_t yaw;
    logic     flip_a;
    logic     flip_b;
    logic     flip_c;
  } e2q_lane_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    logic signed [ZW-1:0] t;
    case (i)
      5'd0: t = 34'sd843314857;
      5'd1: t = 34'sd497837829;
      5'd2: t = 34'sd263043837;
      5'd3: t = 34'sd133525159;
      5'd4: t = 34'sd67021687;
      5'd5: t = 34'sd33543516;
      5'd6: t = 34'sd16775851;
      5'd7: t = 34'sd8388437;
      5'd8: t = 34'sd4194283;
      5'd9: t = 34'sd2097149;
      default: t = 34'sd1 <<< (30 - i);
    endcase
    return t;
  endfunction

endpackage

/* rtl/core/e2q_prep.sv */
// ----------------------------------------------------------------------------
// e2q_prep
// Wrap one half angle, fold into a quarter turn, scale to Q30 radians.
// Three stages: fold, then partial products, then exact divide by 23040.
// ----------------------------------------------------------------------------
module e2q_prep
  import e2q_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] ang,
  output logic signed [ZW-1:0]    z0,
  output logic                    flip
);

  logic signed [17:0] v0, v1, v2;
  logic               f0;
  logic [14:0]        mag_r;
  logic               neg_r, flip_r;
  logic [31:0]        hi_r;
  logic [27:0]        lo_r;
  logic               neg2_r, flip2_r;
  logic [18:0]        lo_q;
  logic [38:0]        prod;
  logic [31:0]        res;
  logic [ZW-1:0]      zo;

  always_comb begin
    v0 = 18'(ang);
    v1 = v0;
    if (v0 >= HALF_TURN) v1 = v0 - 18'sd46080;
    if (v0 < -HALF_TURN) v1 = v0 + 18'sd46080;
    v2 = v1;
    f0 = 1'b0;
    if (v1 > QUARTER_TURN) begin
      v2 = v1 - HALF_TURN;
      f0 = 1'b1;
    end else if (v1 < -QUARTER_TURN) begin
      v2 = v1 + HALF_TURN;
      f0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= v2[17] ? 15'(-v2) : 15'(v2);
      neg_r  <= v2[17];
      flip_r <= f0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_r    <= 32'(mag_r) * 32'(PI_DIV_HI);
      lo_r    <= 28'(mag_r) * 28'(PI_DIV_LO) + 28'(QUARTER_TURN);
      neg2_r  <= neg_r;
      flip2_r <= flip_r;
    end
  end

  always_comb begin
    lo_q = lo_r[27:9];
    prod = 39'(lo_q) * 39'(RECIP_45);
    res  = hi_r + 32'(prod >> RECIP_SHIFT);
    zo   = {2'b00, res};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z0   <= neg2_r ? -$signed(zo) : $signed(zo);
      flip <= flip2_r;
    end
  end

endmodule

/* rtl/core/e2q_cell.sv */
// ----------------------------------------------------------------------------
// e2q_cell
// One CORDIC micro-rotation stage for the three angle lanes.
// ----------------------------------------------------------------------------
module e2q_cell
  import e2q_pkg::*;
#(
  parameter int STEP = 0
) (
  input  logic      clk,
  input  logic      en,
  input  e2q_lane_t lane_i,
  output e2q_lane_t lane_o
);

  function automatic e2q_rot_t rot(input e2q_rot_t a);
    e2q_rot_t r;
    logic signed [ZW-1:0] t;
    t = atan_q30(5'(STEP));
    if (!a.z[ZW-1]) begin
      r.x = a.x - (a.y >>> STEP);
      r.y = a.y + (a.x >>> STEP);
      r.z = a.z - t;
    end else begin
      r.x = a.x + (a.y >>> STEP);
      r.y = a.y - (a.x >>> STEP);
      r.z = a.z + t;
    end
    return r;
  endfunction

  e2q_lane_t lane_nxt;

  always_comb begin
    lane_nxt       = lane_i;
    lane_nxt.roll  = rot(lane_i.roll);
    lane_nxt.pitch = rot(lane_i.pitch);
    lane_nxt.yaw   = rot(lane_i.yaw);
  end

  always_ff @(posedge clk) begin
    if (en) lane_o <= lane_nxt;
  end

endmodule

/* rtl/core/e2q_combine.sv */
// ----------------------------------------------------------------------------
// e2q_combine
// Round sines and cosines, form triple products, sum and saturate.
// ----------------------------------------------------------------------------
module e2q_combine
  import e2q_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  e2q_lane_t             lane_i,
  output logic signed [Q_W-1:0] qx,
  output logic signed [Q_W-1:0] qy,
  output logic signed [Q_W-1:0] qz,
  output logic signed [Q_W-1:0] qw
);

  logic signed [QW-1:0] ca_r, sa_r, cb_r, sb_r, cc_r, sc_r;
  logic signed [QW-1:0] p_cccb_r, p_scsb_r, p_ccsb_r, p_sccb_r;
  logic signed [QW-1:0] ca2_r, sa2_r;
  logic signed [47:0]   t_r [8];
  logic signed [48:0]   s [4];

  function automatic logic signed [QW-1:0] rnd(input logic signed [CW-1:0] v,
                                                 input logic f);
    logic signed [CW-1:0] t;
    logic signed [QW-1:0] q;
    t = (v + 34'sd512) >>> 10;
    q = QW'(t);
    return f ? -q : q;
  endfunction

  function automatic logic signed [QW-1:0] m2(input logic signed [QW-1:0] p,
                                                input logic signed [QW-1:0] q);
    logic signed [47:0] pr;
    pr = 48'(p) * 48'(q) + 48'sd524288;
    return QW'(pr >>> 20);
  endfunction

  function automatic logic signed [Q_W-1:0] sat(input logic signed [48:0] v);
    logic signed [48:0] t;
    t = (v + 49'sd16777216) >>> 25;
    if (t > 49'sd32767) return 16'sh7fff;
    if (t < -49'sd32768) return 16'sh8000;
    return Q_W'(t);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      ca_r <= rnd(lane_i.roll.x, lane_i.flip_a);
      sa_r <= rnd(lane_i.roll.y, lane_i.flip_a);
      cb_r <= rnd(lane_i.pitch.x, lane_i.flip_b);
      sb_r <= rnd(lane_i.pitch.y, lane_i.flip_b);
      cc_r <= rnd(lane_i.yaw.x, lane_i.flip_c);
      sc_r <= rnd(lane_i.yaw.y, lane_i.flip_c);
      p_cccb_r <= m2(cc_r, cb_r);
      p_scsb_r <= m2(sc_r, sb_r);
      p_ccsb_r <= m2(cc_r, sb_r);
      p_sccb_r <= m2(sc_r, cb_r);
      ca2_r <= ca_r;
      sa2_r <= sa_r;
      t_r[0] <= 48'(p_cccb_r) * 48'(sa2_r);
      t_r[1] <= 48'(p_scsb_r) * 48'(ca2_r);
      t_r[2] <= 48'(p_ccsb_r) * 48'(ca2_r);
      t_r[3] <= 48'(p_sccb_r) * 48'(sa2_r);
      t_r[4] <= 48'(p_sccb_r) * 48'(ca2_r);
      t_r[5] <= 48'(p_ccsb_r) * 48'(sa2_r);
      t_r[6] <= 48'(p_cccb_r) * 48'(ca2_r);
      t_r[7] <= 48'(p_scsb_r) * 48'(sa2_r);
      qx <= sat(s[0]);
      qy <= sat(s[1]);
      qz <= sat(s[2]);
      qw <= sat(s[3]);
    end
  end

  always_comb begin
    s[0] = 49'(t_r[0]) - 49'(t_r[1]);
    s[1] = 49'(t_r[2]) + 49'(t_r[3]);
    s[2] = 49'(t_r[4]) - 49'(t_r[5]);
    s[3] = 49'(t_r[6]) + 49'(t_r[7]);
  end

endmodule

/* rtl/core/euler_to_quaternion.sv */
// ----------------------------------------------------------------------------
// euler_to_quaternion
// ZYX Euler angles (1/64 degree) to a Q1.15 unit quaternion.
// ----------------------------------------------------------------------------
// One request is taken every cycle unless the output is stalled. A request
// passes angle folding and scaling, the CORDIC cells, then rounding, products
// and saturation. The pipeline advances whenever the output register is empty
// or being drained; no clearing pass is needed after reset.
module euler_to_quaternion
  import e2q_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // roll_angle, pitch_angle, yaw_angle
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // quat_x, quat_y, quat_z, quat_w
);

  localparam int LAT = CORDIC_STEPS + 7;

  logic [LAT-1:0] vld_r;
  logic           en;
  e2q_lane_t      chain [CORDIC_STEPS+1];
  logic signed [ZW-1:0] za, zb, zc;
  logic           fa, fb, fc;
  logic signed [Q_W-1:0] qx, qy, qz, qw;

  assign en         = !vld_r[LAT-1] || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[LAT-1];
  assign out_tdata  = {qw, qz, qy, qx};

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[LAT-2:0], in_tvalid};
  end

  e2q_prep u_prep_a (.clk, .en, .ang(in_tdata[15:0]),  .z0(za), .flip(fa));
  e2q_prep u_prep_b (.clk, .en, .ang(in_tdata[31:16]), .z0(zb), .flip(fb));
  e2q_prep u_prep_c (.clk, .en, .ang(in_tdata[47:32]), .z0(zc), .flip(fc));

  always_comb begin
    chain[0].roll  = '{x: CORDIC_GAIN, y: '0, z: za};
    chain[0].pitch = '{x: CORDIC_GAIN, y: '0, z: zb};
    chain[0].yaw   = '{x: CORDIC_GAIN, y: '0, z: zc};
    chain[0].flip_a = fa;
    chain[0].flip_b = fb;
    chain[0].flip_c = fc;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
    e2q_cell #(.STEP(i)) u_cell (.clk, .en, .lane_i(chain[i]), .lane_o(chain[i+1]));
  end

  e2q_combine u_comb (
    .clk, .en, .lane_i(chain[CORDIC_STEPS]), .qx, .qy, .qz, .qw
  );

endmodule

/* rtl/core/e2q_checker.sv */
// ----------------------------------------------------------------------------
// e2q_checker
// Port-level checks for euler_to_quaternion.
// ----------------------------------------------------------------------------
module e2q_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("valid after reset");

endmodule

bind euler_to_quaternion e2q_checker u_chk (.*);
